// ===== design/grpt_pkg.sv =====
// Shared types, constants and the quarter-wave sine table for the gait rhythm tracker.
// No dependencies; the top level, front and back part refer to it by scoped names.
package grpt_pkg;

   localparam int START_PERIOD = 60;
   localparam int NUM_LEGS     = 4;
   localparam int QSTEPS       = 256;

   localparam logic [16:0] HYS_Q16    = 17'd13107;
   localparam logic [15:0] INIT_OMEGA = 16'(65536 / START_PERIOD);

   // register indexes of the configuration port
   localparam logic [3:0] CSR_LEG_SIGN_MASK = 4'd0;
   localparam logic [3:0] CSR_MEAN_RATE     = 4'd1;
   localparam logic [3:0] CSR_AMP_RATE      = 4'd2;
   localparam logic [3:0] CSR_PERIOD_RATE   = 4'd3;
   localparam logic [3:0] CSR_OMEGA_RATE    = 4'd4;
   localparam logic [3:0] CSR_PHASE_GAIN    = 4'd5;
   localparam logic [3:0] CSR_PERIOD_FLOOR  = 4'd6;
   localparam logic [3:0] CSR_PERIOD_CEIL   = 4'd7;

   typedef struct packed {
      logic [3:0]  leg_sign_mask;
      logic [15:0] mean_rate;
      logic [15:0] amp_rate;
      logic [15:0] period_rate;
      logic [15:0] omega_rate;
      logic [15:0] phase_gain;
      logic [9:0]  period_floor;
      logic [13:0] period_ceil;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] cos_phase;
      logic signed [15:0] sin_phase;
      logic [15:0]        omega_out;
      logic [15:0]        phase_out;
      logic               crossing_seen;
      logic               locked_flag;
   } rsp_type;

   typedef logic signed [15:0] qsin_type [0:QSTEPS];

   // reciprocals of the series divisors, exact for dividends below 2^32
   localparam logic [63:0] RCP_210 = 64'((64'd1 << 48) / 64'd210 + 64'd1);
   localparam logic [63:0] RCP_156 = 64'((64'd1 << 48) / 64'd156 + 64'd1);
   localparam logic [63:0] RCP_110 = 64'((64'd1 << 48) / 64'd110 + 64'd1);
   localparam logic [63:0] RCP_72  = 64'((64'd1 << 48) / 64'd72 + 64'd1);
   localparam logic [63:0] RCP_42  = 64'((64'd1 << 48) / 64'd42 + 64'd1);
   localparam logic [63:0] RCP_20  = 64'((64'd1 << 48) / 64'd20 + 64'd1);
   localparam logic [63:0] RCP_6   = 64'((64'd1 << 48) / 64'd6 + 64'd1);

   // round(16384 * sin) over a quarter turn, Taylor series in Q30
   function automatic qsin_type build_qsin();
      qsin_type     tab;
      logic [63:0]  x;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  p;
      logic [63:0]  m;
      logic [127:0] wide;
      for (int k = 0; k <= QSTEPS; k++) begin
         x  = (64'(k) * 64'd1686629713) >> 8;
         x2 = (x * x) >> 30;
         t  = 64'd1073741824;
         for (int n = 7; n >= 1; n--) begin
            case (n)
               7: m = RCP_210;
               6: m = RCP_156;
               5: m = RCP_110;
               4: m = RCP_72;
               3: m = RCP_42;
               2: m = RCP_20;
               default: m = RCP_6;
            endcase
            p    = (x2 * t) >> 30;
            wide = 128'(p) * 128'(m);
            t    = 64'd1073741824 - wide[111:48];
         end
         s = (x * t) >> 30;
         tab[k] = 16'((s * 64'd16384 + 64'd536870912) >> 30);
      end
      return tab;
   endfunction

   localparam qsin_type QSIN = build_qsin();

endpackage

// ===== design/grpt_ifs.sv =====
// Channel interfaces of the gait rhythm tracker: tick input, result output, register writes.
// Depends on nothing but plain logic types.
interface grpt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] leg_pos_a;
   logic signed [15:0] leg_pos_b;
   logic signed [15:0] leg_pos_c;
   logic signed [15:0] leg_pos_d;
   modport source (output valid, leg_pos_a, leg_pos_b, leg_pos_c, leg_pos_d, input ready);
   modport sink   (input valid, leg_pos_a, leg_pos_b, leg_pos_c, leg_pos_d, output ready);
endinterface

interface grpt_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] cos_phase;
   logic signed [15:0] sin_phase;
   logic [15:0]        omega_out;
   logic [15:0]        phase_out;
   logic               crossing_seen;
   logic               locked_flag;
   modport source (output valid, cos_phase, sin_phase, omega_out, phase_out, crossing_seen,
                   locked_flag, input ready);
   modport sink   (input valid, cos_phase, sin_phase, omega_out, phase_out, crossing_seen,
                   locked_flag, output ready);
endinterface

interface grpt_csr_if;
   logic        valid;
   logic        ready;
   logic [3:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/gait_rhythm_pll_tracker.sv =====
// Gait rhythm tracker: one tick of four leg positions in, one phase/frequency beat out.
// Each tick runs two or three serial divides (frequency rails, plus the target once locked
// with a period above 256), the multiply/update steps, and the phase pull on a crossing.
// Ticks are worked one at a time; the two-entry queue takes ticks meanwhile.
// Synchronous active-high reset restores the default registers and the tracker state.
module gait_rhythm_pll_tracker (
   input logic        clock,
   input logic        reset,
   grpt_req_if.sink   req_if,
   grpt_rsp_if.source rsp_if,
   grpt_csr_if.sink   csr_if
);
   grpt_pkg::cfg_type  cfg_ff, cfg_in;
   grpt_pkg::rsp_type  out_data;
   logic signed [23:0] raw_sum;
   logic signed [23:0] q_data;
   logic               q_full;
   logic               q_not_empty;
   logic               q_pop;
   logic               push;

   assign csr_if.ready = 1'b1;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_if.valid) begin
         case (csr_if.index)
            grpt_pkg::CSR_LEG_SIGN_MASK: cfg_in.leg_sign_mask = csr_if.data[3:0];
            grpt_pkg::CSR_MEAN_RATE:     cfg_in.mean_rate     = csr_if.data;
            grpt_pkg::CSR_AMP_RATE:      cfg_in.amp_rate      = csr_if.data;
            grpt_pkg::CSR_PERIOD_RATE:   cfg_in.period_rate   = csr_if.data;
            grpt_pkg::CSR_OMEGA_RATE:    cfg_in.omega_rate    = csr_if.data;
            grpt_pkg::CSR_PHASE_GAIN:    cfg_in.phase_gain    = csr_if.data;
            grpt_pkg::CSR_PERIOD_FLOOR:  cfg_in.period_floor  = csr_if.data[9:0];
            grpt_pkg::CSR_PERIOD_CEIL:   cfg_in.period_ceil   = csr_if.data[13:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leg_sign_mask <= 4'd6;
         cfg_ff.mean_rate     <= 16'd328;
         cfg_ff.amp_rate      <= 16'd1311;
         cfg_ff.period_rate   <= 16'd6554;
         cfg_ff.omega_rate    <= 16'd3277;
         cfg_ff.phase_gain    <= 16'd6554;
         cfg_ff.period_floor  <= 10'd16;
         cfg_ff.period_ceil   <= 14'd400;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   grpt_front u_front (
      .leg_sign_mask (cfg_ff.leg_sign_mask),
      .leg_pos_a     (req_if.leg_pos_a),
      .leg_pos_b     (req_if.leg_pos_b),
      .leg_pos_c     (req_if.leg_pos_c),
      .leg_pos_d     (req_if.leg_pos_d),
      .raw_sum       (raw_sum)
   );

   assign req_if.ready = !q_full;
   assign push         = req_if.valid && !q_full;

   grpt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (raw_sum),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .pop_data  (q_data)
   );

   grpt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_not_empty (q_not_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .out_valid   (rsp_if.valid),
      .out_ready   (rsp_if.ready),
      .out_data    (out_data)
   );

   assign rsp_if.cos_phase     = out_data.cos_phase;
   assign rsp_if.sin_phase     = out_data.sin_phase;
   assign rsp_if.omega_out     = out_data.omega_out;
   assign rsp_if.phase_out     = out_data.phase_out;
   assign rsp_if.crossing_seen = out_data.crossing_seen;
   assign rsp_if.locked_flag   = out_data.locked_flag;
endmodule

// ===== design/grpt_front.sv =====
// Front part: forms the sign-masked, scaled leg sum of each accepted tick.
// Depends on grpt_pkg.
module grpt_front (
   input  logic               [3:0]  leg_sign_mask,
   input  logic signed        [15:0] leg_pos_a,
   input  logic signed        [15:0] leg_pos_b,
   input  logic signed        [15:0] leg_pos_c,
   input  logic signed        [15:0] leg_pos_d,
   output logic signed        [23:0] raw_sum
);
   logic signed [15:0] legs [0:3];
   logic signed [18:0] sum;

   assign legs[0] = leg_pos_a;
   assign legs[1] = leg_pos_b;
   assign legs[2] = leg_pos_c;
   assign legs[3] = leg_pos_d;

   // add all four legs, negating those flagged in the mask
   always_comb begin
      sum = '0;
      for (int i = 0; i < grpt_pkg::NUM_LEGS; i++) begin
         if (leg_sign_mask[i]) begin
            sum = sum - 19'(legs[i]);
         end else begin
            sum = sum + 19'(legs[i]);
         end
      end
   end

   // scale by 32
   assign raw_sum = {sum, 5'b0};
endmodule

// ===== design/grpt_queue.sv =====
// Two-entry queue of leg sums between the front and the back part.
// Depends on nothing.
module grpt_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic signed [23:0] push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output logic signed [23:0] pop_data
);
   logic signed [23:0] mem [0:1];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem[rd_ptr_ff];

   // advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write the entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ===== design/grpt_back.sv =====
// Back part: sequencer over one shared multiplier and one serial divider that runs the
// mean, amplitude, crossing, period, frequency and phase updates. Depends on grpt_pkg.
module grpt_back (
   input  logic               clock,
   input  logic               reset,
   input  grpt_pkg::cfg_type  cfg,
   input  logic               q_not_empty,
   input  logic signed [23:0] q_data,
   output logic               q_pop,
   output logic               out_valid,
   input  logic               out_ready,
   output grpt_pkg::rsp_type  out_data
);
   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_MEAN_MUL  = 4'd1;
   localparam logic [3:0] ST_MEAN_UPD  = 4'd2;
   localparam logic [3:0] ST_AMP_MUL   = 4'd3;
   localparam logic [3:0] ST_AMP_UPD   = 4'd4;
   localparam logic [3:0] ST_HYS_MUL   = 4'd5;
   localparam logic [3:0] ST_CROSS     = 4'd6;
   localparam logic [3:0] ST_PER_UPD   = 4'd7;
   localparam logic [3:0] ST_DIV_START = 4'd8;
   localparam logic [3:0] ST_DIV_RUN   = 4'd9;
   localparam logic [3:0] ST_OMEGA_MUL = 4'd10;
   localparam logic [3:0] ST_OMEGA_UPD = 4'd11;
   localparam logic [3:0] ST_PULL_MUL  = 4'd12;
   localparam logic [3:0] ST_PULL_UPD  = 4'd13;
   localparam logic [3:0] ST_OUT       = 4'd14;

   localparam logic [1:0] DIV_HI  = 2'd0;
   localparam logic [1:0] DIV_LO  = 2'd1;
   localparam logic [1:0] DIV_TGT = 2'd2;

   logic [3:0]         state_ff, state_in;
   logic signed [23:0] raw_ff, raw_in;
   logic signed [23:0] mean_ff, mean_in;
   logic [23:0]        amp_ff, amp_in;
   logic signed [24:0] f_ff, f_in;
   logic               below_ff, below_in;
   logic [15:0]        ticks_ff, ticks_in;
   logic [23:0]        period_ff, period_in;
   logic [1:0]         count_ff, count_in;
   logic [15:0]        omega_ff, omega_in;
   logic [15:0]        phase_ff, phase_in;
   logic               crossed_ff, crossed_in;
   logic signed [42:0] prod_ff, prod_in;
   logic [15:0]        whi_ff, whi_in;
   logic [15:0]        wlo_ff, wlo_in;
   logic [16:0]        tgt_ff, tgt_in;
   logic [23:0]        rem_ff, rem_in;
   logic [23:0]        quo_ff, quo_in;
   logic [24:0]        dvd_ff, dvd_in;
   logic [23:0]        dsr_ff, dsr_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [1:0]         dsel_ff, dsel_in;
   logic               out_valid_ff, out_valid_in;
   grpt_pkg::rsp_type  out_ff, out_in;

   logic signed [25:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [42:0] prod_sh;
   logic signed [25:0] mean_sum;
   logic signed [23:0] mean_new;
   logic [24:0]        mag;
   logic signed [25:0] amp_sum;
   logic signed [24:0] hys;
   logic [15:0]        ticks_sat;
   logic [23:0]        t8;
   logic               crossed;
   logic               rearm;
   logic               use_tgt;
   logic [23:0]        pmin_eff;
   logic [23:0]        pmax_eff;
   logic [24:0]        trial;
   logic               ge;
   logic [24:0]        quotient;
   logic [16:0]        tgt_clamp;
   logic signed [17:0] omega_sum;
   logic signed [17:0] omega_clamp;
   logic signed [16:0] err;
   logic [1:0]         quad;
   logic [7:0]         idx;
   logic signed [15:0] sa;
   logic signed [15:0] sb;

   assign prod_sh  = prod_ff >>> 16;
   assign mean_sum = 26'(mean_ff) + prod_sh[25:0];
   assign mean_new = mean_sum[23:0];
   assign mag      = f_ff[24] ? 25'(-f_ff) : 25'(f_ff);
   assign amp_sum  = $signed({2'b0, amp_ff}) + prod_sh[25:0];
   assign hys      = prod_sh[24:0];
   assign ticks_sat = (ticks_ff != 16'hFFFF) ? ticks_ff + 16'd1 : ticks_ff;
   assign t8       = {ticks_sat, 8'b0};
   assign crossed  = below_ff && (f_ff > hys);
   assign rearm    = !below_ff && (f_ff < -hys);
   assign use_tgt  = (count_ff == 2'd2) && (period_ff > 24'd256);
   assign pmin_eff = (cfg.period_floor < 10'd2) ? 24'd2 : 24'(cfg.period_floor);
   assign pmax_eff = (cfg.period_ceil < 14'd2) ? 24'd2 : 24'(cfg.period_ceil);
   assign trial    = {rem_ff, dvd_ff[24]};
   assign ge       = (trial >= {1'b0, dsr_ff});
   assign quotient = {quo_ff, ge};
   assign err      = (phase_ff > 16'd32768) ? 17'(18'sd65536 - $signed({2'b0, phase_ff}))
                                            : -$signed({1'b0, phase_ff});

   // clamp the frequency target: lower rail first, then upper rail
   always_comb begin
      tgt_clamp = tgt_ff;
      if (tgt_clamp < {1'b0, wlo_ff}) tgt_clamp = {1'b0, wlo_ff};
      if (tgt_clamp > {1'b0, whi_ff}) tgt_clamp = {1'b0, whi_ff};
   end

   // update and clamp the frequency estimate
   always_comb begin
      omega_sum = $signed({2'b0, omega_ff});
      if (use_tgt) omega_sum = omega_sum + prod_sh[17:0];
      omega_clamp = omega_sum;
      if (omega_clamp < $signed({2'b0, wlo_ff})) omega_clamp = $signed({2'b0, wlo_ff});
      if (omega_clamp > $signed({2'b0, whi_ff})) omega_clamp = $signed({2'b0, whi_ff});
   end

   // select the shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MEAN_MUL: begin
            mul_a = 26'(raw_ff) - 26'(mean_ff);
            mul_b = $signed({1'b0, cfg.mean_rate});
         end
         ST_AMP_MUL: begin
            mul_a = $signed({1'b0, mag}) - $signed({2'b0, amp_ff});
            mul_b = $signed({1'b0, cfg.amp_rate});
         end
         ST_HYS_MUL: begin
            mul_a = $signed({2'b0, amp_ff});
            mul_b = $signed(grpt_pkg::HYS_Q16);
         end
         ST_CROSS: begin
            mul_a = $signed({2'b0, t8}) - $signed({2'b0, period_ff});
            mul_b = $signed({1'b0, cfg.period_rate});
         end
         ST_OMEGA_MUL: begin
            mul_a = $signed({9'b0, tgt_clamp}) - $signed({10'b0, omega_ff});
            mul_b = $signed({1'b0, cfg.omega_rate});
         end
         ST_PULL_MUL: begin
            mul_a = 26'(err);
            mul_b = $signed({1'b0, cfg.phase_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 43'(mul_a) * 43'(mul_b);

   // look up sine and cosine of the phase
   always_comb begin
      quad = phase_ff[15:14];
      idx  = phase_ff[13:6];
      sa   = grpt_pkg::QSIN[9'(idx)];
      sb   = grpt_pkg::QSIN[9'd256 - 9'(idx)];
      out_in = out_ff;
      case (quad)
         2'd0: begin
            out_in.sin_phase = sa;
            out_in.cos_phase = sb;
         end
         2'd1: begin
            out_in.sin_phase = sb;
            out_in.cos_phase = -sa;
         end
         2'd2: begin
            out_in.sin_phase = -sa;
            out_in.cos_phase = -sb;
         end
         default: begin
            out_in.sin_phase = -sb;
            out_in.cos_phase = sa;
         end
      endcase
      out_in.omega_out     = omega_ff;
      out_in.phase_out     = phase_ff;
      out_in.crossing_seen = crossed_ff;
      out_in.locked_flag   = (count_ff == 2'd2);
   end

   // sequence one tick through the datapath
   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      mean_in      = mean_ff;
      amp_in       = amp_ff;
      f_in         = f_ff;
      below_in     = below_ff;
      ticks_in     = ticks_ff;
      period_in    = period_ff;
      count_in     = count_ff;
      omega_in     = omega_ff;
      phase_in     = phase_ff;
      crossed_in   = crossed_ff;
      whi_in       = whi_ff;
      wlo_in       = wlo_ff;
      tgt_in       = tgt_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      cnt_in       = cnt_ff;
      dsel_in      = dsel_ff;
      q_pop        = 1'b0;
      out_valid_in = out_valid_ff && !out_ready;
      case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               q_pop    = 1'b1;
               raw_in   = q_data;
               state_in = ST_MEAN_MUL;
            end
         end
         ST_MEAN_MUL: state_in = ST_MEAN_UPD;
         ST_MEAN_UPD: begin
            mean_in  = mean_new;
            f_in     = 25'(raw_ff) - 25'(mean_new);
            state_in = ST_AMP_MUL;
         end
         ST_AMP_MUL: state_in = ST_AMP_UPD;
         ST_AMP_UPD: begin
            if (amp_sum < 0) begin
               amp_in = '0;
            end else if (amp_sum > 26'sh0FFFFFF) begin
               amp_in = 24'hFFFFFF;
            end else begin
               amp_in = amp_sum[23:0];
            end
            state_in = ST_HYS_MUL;
         end
         ST_HYS_MUL: state_in = ST_CROSS;
         ST_CROSS: begin
            dsel_in  = DIV_HI;
            state_in = ST_DIV_START;
            if (crossed) begin
               ticks_in   = '0;
               below_in   = 1'b0;
               crossed_in = 1'b1;
               if (count_ff != 2'd2) count_in = count_ff + 2'd1;
               if (period_ff == '0) begin
                  period_in = t8;
               end else begin
                  state_in = ST_PER_UPD;
               end
            end else begin
               ticks_in   = ticks_sat;
               crossed_in = 1'b0;
               if (rearm) below_in = 1'b1;
            end
         end
         ST_PER_UPD: begin
            period_in = 24'($signed({2'b0, period_ff}) + prod_sh[25:0]);
            state_in  = ST_DIV_START;
         end
         ST_DIV_START: begin
            rem_in = '0;
            quo_in = '0;
            cnt_in = '0;
            case (dsel_ff)
               DIV_HI: begin
                  dvd_in = 25'd65536;
                  dsr_in = pmin_eff;
               end
               DIV_LO: begin
                  dvd_in = 25'd65536;
                  dsr_in = pmax_eff;
               end
               default: begin
                  dvd_in = 25'h1000000;
                  dsr_in = period_ff;
               end
            endcase
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            rem_in = ge ? 24'(trial - {1'b0, dsr_ff}) : trial[23:0];
            quo_in = quotient[23:0];
            dvd_in = {dvd_ff[23:0], 1'b0};
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd24) begin
               case (dsel_ff)
                  DIV_HI: begin
                     whi_in   = quotient[15:0];
                     dsel_in  = DIV_LO;
                     state_in = ST_DIV_START;
                  end
                  DIV_LO: begin
                     wlo_in = quotient[15:0];
                     if (use_tgt) begin
                        dsel_in  = DIV_TGT;
                        state_in = ST_DIV_START;
                     end else begin
                        state_in = ST_OMEGA_UPD;
                     end
                  end
                  default: begin
                     tgt_in   = quotient[16:0];
                     state_in = ST_OMEGA_MUL;
                  end
               endcase
            end
         end
         ST_OMEGA_MUL: state_in = ST_OMEGA_UPD;
         ST_OMEGA_UPD: begin
            omega_in = omega_clamp[15:0];
            phase_in = phase_ff + omega_clamp[15:0];
            state_in = crossed_ff ? ST_PULL_MUL : ST_OUT;
         end
         ST_PULL_MUL: state_in = ST_PULL_UPD;
         ST_PULL_UPD: begin
            phase_in = phase_ff + prod_sh[15:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold control and tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mean_ff      <= '0;
         amp_ff       <= '0;
         below_ff     <= 1'b1;
         ticks_ff     <= '0;
         period_ff    <= '0;
         count_ff     <= '0;
         omega_ff     <= grpt_pkg::INIT_OMEGA;
         phase_ff     <= '0;
         crossed_ff   <= 1'b0;
         dsel_ff      <= DIV_HI;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mean_ff      <= mean_in;
         amp_ff       <= amp_in;
         below_ff     <= below_in;
         ticks_ff     <= ticks_in;
         period_ff    <= period_in;
         count_ff     <= count_in;
         omega_ff     <= omega_in;
         phase_ff     <= phase_in;
         crossed_ff   <= crossed_in;
         dsel_ff      <= dsel_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold working values and the result beat
   always_ff @(posedge clock) begin
      raw_ff  <= raw_in;
      f_ff    <= f_in;
      prod_ff <= prod_in;
      whi_ff  <= whi_in;
      wlo_ff  <= wlo_in;
      tgt_ff  <= tgt_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvd_ff  <= dvd_in;
      dsr_ff  <= dsr_in;
      if (state_ff == ST_OUT && (!out_valid_ff || out_ready)) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;
endmodule

// ===== design/grpt_checker.sv =====
// Port-level checks of the gait rhythm tracker's result channel, bound to the top level.
// Depends on gait_rhythm_pll_tracker.
module grpt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] cos_phase,
   input logic signed [15:0] sin_phase,
   input logic [15:0]        omega_out,
   input logic [15:0]        phase_out
);
   // a stalled beat stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled beat holds its phase and frequency
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(phase_out) && $stable(omega_out))
      else $error("result payload changed while stalled");

   // no beat straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // frequency stays inside its rails and the table stays in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> omega_out != 16'd0 && omega_out <= 16'd32768 &&
                    cos_phase <= 16'sd16384 && cos_phase >= -16'sd16384 &&
                    sin_phase <= 16'sd16384 && sin_phase >= -16'sd16384)
      else $error("result field out of range");
endmodule

bind gait_rhythm_pll_tracker grpt_checker u_grpt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .cos_phase (rsp_if.cos_phase),
   .sin_phase (rsp_if.sin_phase),
   .omega_out (rsp_if.omega_out),
   .phase_out (rsp_if.phase_out)
);
